FILE: rtl/rap_pkg.sv
// ----------------------------------------------------------------------------
// rap_pkg
// Shared constants and controller/datapath interface types for the
// Ruth-Aaron pair test.
// ----------------------------------------------------------------------------
package rap_pkg;

  // default width of the tested number
  localparam int NUMBER_BITS_DEF = 24;

  // controller -> datapath commands
  typedef struct packed {
    logic capture;   // latch input number
    logic start;     // begin a pass: load m, d = 2, total = 0
    logic second;    // pass works on n+1 rather than n
    logic div_init;  // load divider with m
    logic div_step;  // one restoring division step
    logic take;      // divisor hit: m = quotient, add d once
    logic next_d;    // divisor missed: d = d + 1
    logic finish;    // add leftover factor, store pass sum
    logic push;      // move sums to output register
  } rap_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic sq_le;     // d*d <= m
    logic found;     // current d already divides m at least once
    logic div_last;  // final division step in progress
    logic rem_zero;  // remainder of last division is zero
    logic out_free;  // output register can take a word this cycle
  } rap_sts_t;

endpackage

FILE: rtl/rap_ctrl.sv
// ----------------------------------------------------------------------------
// rap_ctrl
// Sequencer for the trial-division loop: two passes (n, n+1), each a scan
// of divisors with a multi-cycle division per trial.
// ----------------------------------------------------------------------------
module rap_ctrl
  import rap_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  rap_sts_t sts,
  output rap_cmd_t cmd
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_START = 7'b0000010,
    S_CHECK = 7'b0000100,
    S_DIV   = 7'b0001000,
    S_TEST  = 7'b0010000,
    S_TAIL  = 7'b0100000,
    S_DONE  = 7'b1000000
  } rap_state_t;

  rap_state_t state_r, state_nxt;
  logic       pass_r, pass_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt  = state_r;
    pass_nxt   = pass_r;
    cmd        = '0;
    cmd.second = pass_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          pass_nxt    = 1'b0;
          state_nxt   = S_START;
        end
      end
      S_START: begin
        cmd.start = 1'b1;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        // keep dividing by the same d until it no longer divides m
        if (sts.found || sts.sq_le) begin
          cmd.div_init = 1'b1;
          state_nxt    = S_DIV;
        end else begin
          state_nxt = S_TAIL;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_TEST;
        end
      end
      S_TEST: begin
        if (sts.rem_zero) begin
          cmd.take = 1'b1;
        end else begin
          cmd.next_d = 1'b1;
        end
        state_nxt = S_CHECK;
      end
      S_TAIL: begin
        cmd.finish = 1'b1;
        if (!pass_r) begin
          pass_nxt  = 1'b1;
          state_nxt = S_START;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.push  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pass_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pass_r  <= pass_nxt;
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == S_START && !pass_r))
    else $error("accepted word did not start first pass");

  a_div_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && sts.div_last) |=> (state_r == S_TEST))
    else $error("division did not end after final step");

  a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> sts.out_free)
    else $error("push into occupied output register");

endmodule

FILE: rtl/rap_dpath.sv
// ----------------------------------------------------------------------------
// rap_dpath
// Datapath: working value, divisor, running sum, restoring divider
// (one quotient bit per cycle) and the output register.
// ----------------------------------------------------------------------------
module rap_dpath
  import rap_pkg::*;
#(
  parameter int NUMBER_BITS = NUMBER_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  rap_cmd_t               cmd,
  output rap_sts_t               sts,
  input  logic [NUMBER_BITS-1:0] in_number,
  input  logic                   out_tready,
  output logic                   out_tvalid,
  output logic [NUMBER_BITS-1:0] out_number_echo,
  output logic [NUMBER_BITS-1:0] out_sum_first,
  output logic [NUMBER_BITS-1:0] out_sum_second,
  output logic                   out_is_pair
);

  localparam int MW   = NUMBER_BITS + 1;            // n+1 needs one more bit
  localparam int DW   = (NUMBER_BITS + 1) / 2 + 1;  // divisor reaches sqrt(2^MW-1)+1
  localparam int SQW  = 2 * DW;
  localparam int CNTW = $clog2(MW);

  logic [NUMBER_BITS-1:0] number_r;
  logic [MW-1:0]          m_r;
  logic [DW-1:0]          d_r;
  logic [MW-1:0]          total_r;
  logic                   found_r;
  logic [MW-1:0]          quo_r;
  logic [DW-1:0]          rem_r;
  logic [CNTW-1:0]        cnt_r;
  logic [MW-1:0]          s1_r, s2_r;
  logic                   out_valid_r;
  logic [NUMBER_BITS-1:0] o_num_r, o_s1_r, o_s2_r;
  logic                   o_pair_r;

  logic [SQW-1:0] sq;
  logic [DW:0]    trial;
  logic [DW:0]    diff;
  logic           ge;
  logic [MW-1:0]  tail_sum;
  logic [MW-1:0]  start_m;

  assign sq    = SQW'(d_r) * SQW'(d_r);
  assign trial = {rem_r, quo_r[MW-1]};
  assign diff  = trial - {1'b0, d_r};
  assign ge    = (trial >= {1'b0, d_r});

  // leftover above one after the scan is prime
  assign tail_sum = total_r + ((m_r > MW'(1)) ? m_r : '0);
  assign start_m  = cmd.second ? ({1'b0, number_r} + MW'(1)) : {1'b0, number_r};

  assign sts.sq_le    = (sq <= SQW'(m_r));
  assign sts.found    = found_r;
  assign sts.div_last = (cnt_r == CNTW'(MW - 1));
  assign sts.rem_zero = (rem_r == '0);
  assign sts.out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      number_r <= in_number;
    end
    if (cmd.start) begin
      m_r     <= start_m;
      d_r     <= DW'(2);
      total_r <= '0;
      found_r <= 1'b0;
    end
    if (cmd.div_init) begin
      quo_r <= m_r;
      rem_r <= '0;
      cnt_r <= '0;
    end
    if (cmd.div_step) begin
      quo_r <= {quo_r[MW-2:0], ge};
      rem_r <= ge ? diff[DW-1:0] : trial[DW-1:0];
      cnt_r <= cnt_r + CNTW'(1);
    end
    if (cmd.take) begin
      m_r     <= quo_r;
      found_r <= 1'b1;
      if (!found_r) begin
        total_r <= total_r + MW'(d_r);
      end
    end
    if (cmd.next_d) begin
      d_r     <= d_r + DW'(1);
      found_r <= 1'b0;
    end
    if (cmd.finish) begin
      if (cmd.second) begin
        s2_r <= tail_sum;
      end else begin
        s1_r <= tail_sum;
      end
    end
    if (cmd.push) begin
      o_num_r  <= number_r;
      o_s1_r   <= s1_r[NUMBER_BITS-1:0];
      o_s2_r   <= s2_r[NUMBER_BITS-1:0];
      o_pair_r <= (s1_r == s2_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.push) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid      = out_valid_r;
  assign out_number_echo = o_num_r;
  assign out_sum_first   = o_s1_r;
  assign out_sum_second  = o_s2_r;
  assign out_is_pair     = o_pair_r;

  a_push_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |=> out_valid_r)
    else $error("output word not presented after push");

  a_rem_below_d: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |=> (rem_r < d_r))
    else $error("partial remainder not below divisor");

  a_start_init: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |=> (d_r == DW'(2) && total_r == '0 && !found_r))
    else $error("pass did not initialise divisor and sum");

endmodule

FILE: rtl/ruth_aaron_pair_test.sv
// Sequence: per number m, each trial divisor runs a check, NUMBER_BITS+1 divider steps and a
//   test; a prime m needs about sqrt(m) trials, and n and n+1 are scanned one after the other.
// Throughput: one word at a time, set by the one-bit-per-cycle restoring divider; the next
//   input is taken once the result sits in the output register.
// Reset: synchronous active-low rst_n returns the sequencer to idle and empties the output.
// ----------------------------------------------------------------------------
// ruth_aaron_pair_test
// Sums the distinct prime factors of n and n+1 by trial division and flags
// a Ruth-Aaron pair when the sums match.
// ----------------------------------------------------------------------------
module ruth_aaron_pair_test
  import rap_pkg::*;
#(
  parameter int NUMBER_BITS = NUMBER_BITS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  // input word
  input  logic                                     in_tvalid,
  output logic                                     in_tready,
  input  logic [((NUMBER_BITS + 7) / 8) * 8 - 1:0] in_tdata,   // [NB-1:0] number
  // result word
  output logic                                     out_tvalid,
  input  logic                                     out_tready,
  // fields from bit 0: number_echo, sum_first, sum_second, is_pair, zero pad
  output logic [((3 * NUMBER_BITS + 8) / 8) * 8 - 1:0] out_tdata
);

  localparam int OUT_W   = ((3 * NUMBER_BITS + 8) / 8) * 8;
  localparam int OUT_PAD = OUT_W - (3 * NUMBER_BITS + 1);

  rap_cmd_t cmd;
  rap_sts_t sts;

  logic [NUMBER_BITS-1:0] number_echo;
  logic [NUMBER_BITS-1:0] sum_first;
  logic [NUMBER_BITS-1:0] sum_second;
  logic                   is_pair;

  // sequencer: pass order, divisor scan, divider timing, output handover
  rap_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // arithmetic and result register; pad bits of in_tdata are ignored
  rap_dpath #(
    .NUMBER_BITS (NUMBER_BITS)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_number       (in_tdata[NUMBER_BITS-1:0]),
    .out_tready      (out_tready),
    .out_tvalid      (out_tvalid),
    .out_number_echo (number_echo),
    .out_sum_first   (sum_first),
    .out_sum_second  (sum_second),
    .out_is_pair     (is_pair)
  );

  // pack result word, lowest field first, zero-filled to a byte boundary
  if (OUT_PAD > 0) begin : g_pad
    assign out_tdata = {{OUT_PAD{1'b0}}, is_pair, sum_second, sum_first, number_echo};
  end else begin : g_nopad
    assign out_tdata = {is_pair, sum_second, sum_first, number_echo};
  end

endmodule
